// ===== rtl/core/blocked_grid_point_file_offset_core_assert.svh =====
// assertion macros shared by the checker
`ifndef BLOCKED_GRID_POINT_FILE_OFFSET_CORE_ASSERT_SVH
`define BLOCKED_GRID_POINT_FILE_OFFSET_CORE_ASSERT_SVH

// check while out of reset
`define GBO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also spans reset
`define GBO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/gbo_pkg.sv =====
package gbo_pkg;

    localparam int EXT_W = 13;
    localparam int BLK_W = 9;
    localparam int CRD_W = 12;
    localparam int SZ_W  = 13;
    localparam int OFF_W = 40;
    localparam int IDX_W = 8;
    localparam int NAX   = 3;
    localparam int AZ    = 0;
    localparam int AY    = 1;
    localparam int AX    = 2;

    localparam logic [OFF_W-1:0] FILE_HDR_BYTES = 40'd64;

    typedef enum logic [2:0] {
        CFG_EXT_X = 3'd0,
        CFG_EXT_Y = 3'd1,
        CFG_EXT_Z = 3'd2,
        CFG_BLK_X = 3'd3,
        CFG_BLK_Y = 3'd4,
        CFG_BLK_Z = 3'd5
    } t_cfg_idx;

    // sideband along the first divider
    typedef struct packed {
        logic [NAX-1:0][CRD_W-1:0] crd;
        logic                      bad;
    } t_sd1;

    // sideband along the second divider
    typedef struct packed {
        logic [NAX-1:0][CRD_W-1:0] crd;
        logic                      bad;
        logic [NAX-1:0][BLK_W-1:0] base;
        logic [NAX-1:0][SZ_W-1:0]  size;
    } t_sd2;

endpackage

// ===== rtl/core/gbo_div.sv =====
module gbo_div #(
    parameter int LN = 3,
    parameter int NW = 13,
    parameter int DW = 9,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [LN-1:0][NW-1:0]  i_num,
    input  logic [LN-1:0][DW-1:0]  i_den,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [LN-1:0][NW-1:0]  o_quo,
    output logic [LN-1:0][DW-1:0]  o_rem,
    output logic [SW-1:0]          o_side
);
    // one quotient bit per stage, msb first
    logic                  r_v    [NW];
    logic [LN-1:0][NW-1:0] r_num  [NW];
    logic [LN-1:0][DW-1:0] r_den  [NW];
    logic [LN-1:0][DW-1:0] r_rem  [NW];
    logic [SW-1:0]         r_side [NW];
    logic [NW:0]           rdy;

    assign rdy[NW] = i_ready;

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic                  v_in;
        logic [LN-1:0][NW-1:0] num_in;
        logic [LN-1:0][DW-1:0] den_in;
        logic [LN-1:0][DW-1:0] rem_in;
        logic [SW-1:0]         side_in;
        logic [LN-1:0][NW-1:0] n_num;
        logic [LN-1:0][DW-1:0] n_rem;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign num_in  = i_num;
            assign den_in  = i_den;
            assign rem_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign rem_in  = r_rem[k-1];
            assign side_in = r_side[k-1];
        end

        assign rdy[k] = !r_v[k] || rdy[k+1];

        always_comb begin
            logic [DW:0] t;
            logic        ge;
            for (int l = 0; l < LN; l++) begin
                t        = {rem_in[l], num_in[l][NW-1]};
                ge       = (t >= {1'b0, den_in[l]});
                n_rem[l] = ge ? DW'(t - {1'b0, den_in[l]}) : t[DW-1:0];
                n_num[l] = {num_in[l][NW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_num[k]  <= n_num;
                r_den[k]  <= den_in;
                r_rem[k]  <= n_rem;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[NW-1];
    assign o_quo   = r_num[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// ===== rtl/core/gbo_prep.sv =====
module gbo_prep (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [gbo_pkg::NAX-1:0][gbo_pkg::SZ_W-1:0]  i_sz,
    input  logic [gbo_pkg::NAX-1:0][gbo_pkg::BLK_W-1:0] i_rm,
    input  gbo_pkg::t_sd1                          i_sd,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [gbo_pkg::NAX-1:0][gbo_pkg::CRD_W-1:0] o_num,
    output logic [gbo_pkg::NAX-1:0][gbo_pkg::SZ_W-1:0]  o_den,
    output gbo_pkg::t_sd2                          o_sd
);
    import gbo_pkg::*;

    localparam int SPL_W = BLK_W + SZ_W + 1;

    logic                           r1_v;
    logic [NAX-1:0][SZ_W-1:0]       r1_sz;
    logic [NAX-1:0][BLK_W-1:0]      r1_rm;
    logic [NAX-1:0][SPL_W-1:0]      r1_split;
    t_sd1                           r1_sd;
    logic                           r2_v;
    logic [NAX-1:0][CRD_W-1:0]      r2_num;
    logic [NAX-1:0][SZ_W-1:0]       r2_den;
    t_sd2                           r2_sd;

    logic                           rdy1, rdy2;
    logic [NAX-1:0][SPL_W-1:0]      n_split;
    logic [NAX-1:0][CRD_W-1:0]      n_num;
    logic [NAX-1:0][SZ_W-1:0]       n_den;
    t_sd2                           n_sd;

    assign rdy2    = !r2_v || i_ready;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    // points held by the larger remainder subgrids
    always_comb begin
        for (int l = 0; l < NAX; l++) begin
            n_split[l] = SPL_W'(i_rm[l]) * (SPL_W'(i_sz[l]) + SPL_W'(1));
        end
    end

    always_comb begin
        logic lt;
        n_sd.crd = r1_sd.crd;
        n_sd.bad = r1_sd.bad;
        for (int l = 0; l < NAX; l++) begin
            lt           = (SPL_W'(r1_sd.crd[l]) < r1_split[l]);
            n_num[l]     = lt ? r1_sd.crd[l]
                              : CRD_W'(SPL_W'(r1_sd.crd[l]) - r1_split[l]);
            n_den[l]     = lt ? SZ_W'(r1_sz[l] + SZ_W'(1)) : r1_sz[l];
            n_sd.base[l] = lt ? '0 : r1_rm[l];
            n_sd.size[l] = n_den[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_v <= i_valid;
            end
            if (rdy2) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_sz    <= i_sz;
            r1_rm    <= i_rm;
            r1_split <= n_split;
            r1_sd    <= i_sd;
        end
        if (rdy2) begin
            r2_num <= n_num;
            r2_den <= n_den;
            r2_sd  <= n_sd;
        end
    end

    assign o_valid = r2_v;
    assign o_num   = r2_num;
    assign o_den   = r2_den;
    assign o_sd    = r2_sd;

endmodule

// ===== rtl/core/gbo_acc.sv =====
module gbo_acc (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [gbo_pkg::NAX-1:0][gbo_pkg::CRD_W-1:0] i_quo,
    input  logic [gbo_pkg::NAX-1:0][gbo_pkg::SZ_W-1:0]  i_rem,
    input  gbo_pkg::t_sd2                          i_sd,
    input  logic [gbo_pkg::EXT_W-1:0]              i_nx,
    input  logic [gbo_pkg::EXT_W-1:0]              i_ny,
    input  logic [gbo_pkg::BLK_W-1:0]              i_bx,
    input  logic [gbo_pkg::BLK_W-1:0]              i_by,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [gbo_pkg::OFF_W-1:0]              o_off,
    output logic [gbo_pkg::NAX-1:0][gbo_pkg::IDX_W-1:0] o_idx,
    output logic                                   o_bad
);
    import gbo_pkg::*;

    localparam int P1_W = 2 * EXT_W;
    localparam int H_W  = 28;

    // stage a: axis start and index, first products
    logic                      ra_v, ra_bad;
    logic [NAX-1:0][BLK_W-1:0] ra_idx;
    logic [NAX-1:0][SZ_W-1:0]  ra_rk;
    logic [CRD_W-1:0]          ra_zs, ra_xs;
    logic [SZ_W-1:0]           ra_zsz, ra_xsz;
    logic [P1_W-1:0]           ra_nxny, ra_nxys, ra_yzsz, ra_yxsz;
    logic [H_W-1:0]            ra_bxby, ra_bxyi;
    // stage b: terms
    logic                      rb_v, rb_bad;
    logic [NAX-1:0][BLK_W-1:0] rb_idx;
    logic [OFF_W-1:0]          rb_t0, rb_t1, rb_t2, rb_t3, rb_t4;
    logic [H_W-1:0]            rb_h0, rb_bxyi;
    logic [SZ_W-1:0]           rb_xr;
    // stage c: sums
    logic                      rc_v, rc_bad;
    logic [NAX-1:0][BLK_W-1:0] rc_idx;
    logic [OFF_W-1:0]          rc_elems;
    logic [H_W-1:0]            rc_hdrs;
    // stage d: output register
    logic                      rd_v, rd_bad;
    logic [NAX-1:0][IDX_W-1:0] rd_idx;
    logic [OFF_W-1:0]          rd_off;

    logic rdy_a, rdy_b, rdy_c, rdy_d;
    logic [NAX-1:0][CRD_W-1:0] n_st;
    logic [NAX-1:0][BLK_W-1:0] n_idx;

    assign rdy_d   = !rd_v || i_ready;
    assign rdy_c   = !rc_v || rdy_d;
    assign rdy_b   = !rb_v || rdy_c;
    assign rdy_a   = !ra_v || rdy_b;
    assign o_ready = rdy_a;

    always_comb begin
        for (int l = 0; l < NAX; l++) begin
            n_st[l]  = i_sd.crd[l] - i_rem[l][CRD_W-1:0];
            n_idx[l] = BLK_W'(CRD_W'(i_sd.base[l]) + i_quo[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
            rb_v <= 1'b0;
            rc_v <= 1'b0;
            rd_v <= 1'b0;
        end else begin
            if (rdy_a) ra_v <= i_valid;
            if (rdy_b) rb_v <= ra_v;
            if (rdy_c) rc_v <= rb_v;
            if (rdy_d) rd_v <= rc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            ra_bad  <= i_sd.bad;
            ra_idx  <= n_idx;
            ra_rk   <= i_rem;
            ra_zs   <= n_st[AZ];
            ra_xs   <= n_st[AX];
            ra_zsz  <= i_sd.size[AZ];
            ra_xsz  <= i_sd.size[AX];
            ra_nxny <= P1_W'(i_nx) * P1_W'(i_ny);
            ra_nxys <= P1_W'(i_nx) * P1_W'(n_st[AY]);
            ra_yzsz <= P1_W'(i_sd.size[AY]) * P1_W'(i_sd.size[AZ]);
            ra_yxsz <= P1_W'(i_sd.size[AY]) * P1_W'(i_sd.size[AX]);
            ra_bxby <= H_W'(i_bx) * H_W'(i_by);
            ra_bxyi <= H_W'(i_bx) * H_W'(n_idx[AY]);
        end
        if (rdy_b) begin
            rb_bad  <= ra_bad;
            rb_idx  <= ra_idx;
            rb_t0   <= OFF_W'(ra_nxny) * OFF_W'(ra_zs);
            rb_t1   <= OFF_W'(ra_nxys) * OFF_W'(ra_zsz);
            rb_t2   <= OFF_W'(ra_xs) * OFF_W'(ra_yzsz);
            rb_t3   <= OFF_W'(ra_rk[AZ]) * OFF_W'(ra_yxsz);
            rb_t4   <= OFF_W'(ra_rk[AY]) * OFF_W'(ra_xsz);
            rb_h0   <= ra_bxby * H_W'(ra_idx[AZ]);
            rb_bxyi <= ra_bxyi;
            rb_xr   <= ra_rk[AX];
        end
        if (rdy_c) begin
            rc_bad   <= rb_bad;
            rc_idx   <= rb_idx;
            rc_elems <= rb_t0 + rb_t1 + rb_t2 + rb_t3 + rb_t4 + OFF_W'(rb_xr);
            rc_hdrs  <= rb_h0 + rb_bxyi + H_W'(rb_idx[AX]) + H_W'(1);
        end
        if (rdy_d) begin
            rd_bad <= rc_bad;
            for (int l = 0; l < NAX; l++) begin
                rd_idx[l] <= rc_bad ? '0 : rc_idx[l][IDX_W-1:0];
            end
            // 36 * hdrs as two shifts
            rd_off <= rc_bad ? '0
                    : FILE_HDR_BYTES + (OFF_W'(rc_hdrs) << 5) + (OFF_W'(rc_hdrs) << 2)
                      + (rc_elems << 3);
        end
    end

    assign o_valid = rd_v;
    assign o_off   = rd_off;
    assign o_idx   = rd_idx;
    assign o_bad   = rd_bad;

endmodule

// ===== rtl/core/blocked_grid_point_file_offset_core.sv =====
// point to file offset lookup for a blocked grid file
// slave stream: one request per point, tdata holds coord_z, coord_y, coord_x
// master stream: one result per request, in request order; tdata holds the
//   byte offset and the three subgrid indices, tuser the out-of-range flag
// cfg port: write extents and block counts while no request is in flight;
//   they take effect for the next request, index 6 and 7 are ignored
// a request passes the extent / block count divider (one bit a stage), the split
//   and select, the coordinate divider, and the multiply, sum and offset stages
// takes one request per cycle unless the master stalls; each stage carries its own valid bit
// a stalled master side fills empty stages first, so the slave stays ready
//   until the whole pipe holds work; nothing is dropped or repeated
// reset clears all valid bits and sets every extent and block count to 1
// out-of-range results carry zero offset and zero indices
module blocked_grid_point_file_offset_core #(
    parameter int MAX_EXTENT = 4096,
    parameter int MAX_BLOCKS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // coord_z[11:0], coord_y[23:12], coord_x[35:24], zero pad
    // master result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // byte_offset[39:0], block_index_z[47:40],
                                     // block_index_y[55:48], block_index_x[63:56]
    output logic        o_m_tuser,   // out_of_range
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data
);
    import gbo_pkg::*;

    logic [NAX-1:0][EXT_W-1:0] r_ext;
    logic [NAX-1:0][BLK_W-1:0] r_blk;

    // config registers, lane order z, y, x
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NAX; l++) begin
                r_ext[l] <= EXT_W'(1);
                r_blk[l] <= BLK_W'(1);
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_EXT_X: r_ext[AX] <= i_cfg_data;
                CFG_EXT_Y: r_ext[AY] <= i_cfg_data;
                CFG_EXT_Z: r_ext[AZ] <= i_cfg_data;
                CFG_BLK_X: r_blk[AX] <= i_cfg_data[BLK_W-1:0];
                CFG_BLK_Y: r_blk[AY] <= i_cfg_data[BLK_W-1:0];
                CFG_BLK_Z: r_blk[AZ] <= i_cfg_data[BLK_W-1:0];
                default: ;
            endcase
        end
    end

    // range check at the input, carried down the pipe as a flag
    t_sd1 sd_in;
    always_comb begin
        logic bad;
        bad = 1'b0;
        for (int l = 0; l < NAX; l++) begin
            sd_in.crd[l] = i_s_tdata[l*CRD_W +: CRD_W];
            if (r_ext[l] == '0 || 32'(r_ext[l]) > MAX_EXTENT ||
                r_blk[l] == '0 || 32'(r_blk[l]) > MAX_BLOCKS ||
                EXT_W'(r_blk[l]) > r_ext[l] ||
                EXT_W'(sd_in.crd[l]) >= r_ext[l]) begin
                bad = 1'b1;
            end
        end
        sd_in.bad = bad;
    end

    // extent / block count: normal subgrid size and remainder count
    logic                      d1_valid, d1_ready;
    logic [NAX-1:0][SZ_W-1:0]  d1_sz;
    logic [NAX-1:0][BLK_W-1:0] d1_rm;
    logic [$bits(t_sd1)-1:0]   d1_side;

    gbo_div #(
        .LN (NAX),
        .NW (EXT_W),
        .DW (BLK_W),
        .SW ($bits(t_sd1))
    ) u_div_ext (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_num   (r_ext),
        .i_den   (r_blk),
        .i_side  (sd_in),
        .o_valid (d1_valid),
        .i_ready (d1_ready),
        .o_quo   (d1_sz),
        .o_rem   (d1_rm),
        .o_side  (d1_side)
    );

    // pick remainder or normal region, set divisor and index base
    logic                      p_valid, p_ready;
    logic [NAX-1:0][CRD_W-1:0] p_num;
    logic [NAX-1:0][SZ_W-1:0]  p_den;
    t_sd2                      p_sd;

    gbo_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_valid),
        .o_ready (d1_ready),
        .i_sz    (d1_sz),
        .i_rm    (d1_rm),
        .i_sd    (t_sd1'(d1_side)),
        .o_valid (p_valid),
        .i_ready (p_ready),
        .o_num   (p_num),
        .o_den   (p_den),
        .o_sd    (p_sd)
    );

    // coordinate / subgrid size: index within region and rank in subgrid
    logic                      d2_valid, d2_ready;
    logic [NAX-1:0][CRD_W-1:0] d2_quo;
    logic [NAX-1:0][SZ_W-1:0]  d2_rem;
    logic [$bits(t_sd2)-1:0]   d2_side;

    gbo_div #(
        .LN (NAX),
        .NW (CRD_W),
        .DW (SZ_W),
        .SW ($bits(t_sd2))
    ) u_div_crd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .o_ready (p_ready),
        .i_num   (p_num),
        .i_den   (p_den),
        .i_side  (p_sd),
        .o_valid (d2_valid),
        .i_ready (d2_ready),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    // element and header counts, final offset
    logic [OFF_W-1:0]          a_off;
    logic [NAX-1:0][IDX_W-1:0] a_idx;
    logic                      a_bad;

    gbo_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d2_valid),
        .o_ready (d2_ready),
        .i_quo   (d2_quo),
        .i_rem   (d2_rem),
        .i_sd    (t_sd2'(d2_side)),
        .i_nx    (r_ext[AX]),
        .i_ny    (r_ext[AY]),
        .i_bx    (r_blk[AX]),
        .i_by    (r_blk[AY]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_off   (a_off),
        .o_idx   (a_idx),
        .o_bad   (a_bad)
    );

    assign o_m_tdata = {a_idx[AX], a_idx[AY], a_idx[AZ], a_off};
    assign o_m_tuser = a_bad;

endmodule

// ===== rtl/core/gbo_chk.sv =====
`include "blocked_grid_point_file_offset_core_assert.svh"

module gbo_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser
);
    // a stalled result stays up
    `GBO_ASSERT(a_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped under stall")
    // flagged results carry zeros
    `GBO_ASSERT(a_bad_zero, o_m_tvalid && o_m_tuser |-> o_m_tdata == 64'd0, "flagged result not zero")
    // good results sit past file and subgrid header
    `GBO_ASSERT(a_min_off, o_m_tvalid && !o_m_tuser |-> o_m_tdata[39:0] >= 40'd100, "offset below headers")
    // pipe empties on reset
    `GBO_ASSERT_RST(a_rst, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
endmodule

bind blocked_grid_point_file_offset_core gbo_chk u_gbo_chk (.*);
